// File: hdl/hicdf_pkg.sv
// Package for the histogram inverse-CDF sampler.
// Holds command and status codes, the sequencer state type and the data width.
// No dependencies.
`default_nettype none
package hicdf_pkg;

  localparam int DATA_W = 32;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_SAMPLE = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_OVERLAP = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_EMPTY   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_MUL,
    ST_ADD_WR,
    ST_SCALE,
    ST_WALK,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } hicdf_state_t;

endpackage
`default_nettype wire

// File: hdl/hicdf_in_if.sv
// Command channel of the histogram sampler: valid/ready plus command payload.
// No dependencies.
`default_nettype none
interface hicdf_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  cmd;
  logic signed [31:0] bar_offset_in;
  logic        [31:0] bar_width_in;
  logic        [31:0] bar_height_in;
  logic        [31:0] uniform_draw;

  modport source (output valid, cmd, bar_offset_in, bar_width_in, bar_height_in,
                  uniform_draw, input ready);
  modport sink (input valid, cmd, bar_offset_in, bar_width_in, bar_height_in,
                uniform_draw, output ready);
endinterface
`default_nettype wire

// File: hdl/hicdf_out_if.sv
// Result channel of the histogram sampler: valid/ready plus result payload.
// The bar count width follows the table depth.
`default_nettype none
interface hicdf_out_if #(parameter int CNT_W = 9);
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_value;
  logic        [1:0]  status;
  logic [CNT_W-1:0]   bar_total;

  modport source (output valid, sample_value, status, bar_total, input ready);
  modport sink (input valid, sample_value, status, bar_total, output ready);
endinterface
`default_nettype wire

// File: hdl/hicdf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module hicdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hdl/histogram_inverse_cdf_sampler_unit.sv
// Histogram inverse-CDF sampler: clear, add bar, draw sample.
// A clear goes straight to the result; an add multiplies and then writes the bar; a sample
// scales the draw, walks the bars and divides, but a zero-height bar skips the division.
// One transaction at a time.
// The bar walk reads one bar a cycle from the bar RAM; the quotient takes one bit a cycle.
// Reset (synchronous, rst_n low) empties the table; the bar RAM is not cleared.
`default_nettype none
module histogram_inverse_cdf_sampler_unit
  import hicdf_pkg::*;
#(
  parameter int MAX_BARS  = 256,
  parameter int FRAC_BITS = 16
) (
  input wire logic  clk,
  input wire logic  rst_n,
  hicdf_in_if.sink  in_ch,
  hicdf_out_if.source out_ch
);

  localparam int CNT_W  = $clog2(MAX_BARS + 1);
  localparam int IDX_W  = $clog2(MAX_BARS);
  localparam int AREA_W = 2 * DATA_W - FRAC_BITS;
  localparam int SUM_W  = AREA_W + IDX_W;
  localparam int QW     = SUM_W + FRAC_BITS;
  localparam int DCNT_W = $clog2(QW + 1);
  localparam int RAM_W  = 2 * DATA_W + AREA_W;

  hicdf_state_t       state_r, state_nxt;
  logic [1:0]         cmd_r, cmd_nxt;
  logic [31:0]        off_r, off_nxt;
  logic [31:0]        wid_r, wid_nxt;
  logic [31:0]        hgt_r, hgt_nxt;
  logic [31:0]        u_r, u_nxt;
  logic [63:0]        prod_r, prod_nxt;
  logic [CNT_W-1:0]   held_r, held_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [33:0]        prev_end_r, prev_end_nxt;
  logic [SUM_W-1:0]   pick_r, pick_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [DCNT_W-1:0]  cnt_r, cnt_nxt;
  logic [QW-1:0]      dq_r, dq_nxt;
  logic [31:0]        rem_r, rem_nxt;
  logic [31:0]        val_r, val_nxt;
  logic [1:0]         stat_r, stat_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        out_val_r, out_val_nxt;
  logic [1:0]         out_stat_r, out_stat_nxt;
  logic [CNT_W-1:0]   out_total_r, out_total_nxt;

  logic               ram_we;
  logic [RAM_W-1:0]   ram_wdata, ram_rdata;
  logic [31:0]        rd_off, rd_hgt;
  logic [AREA_W-1:0]  rd_area, new_area;
  logic [SUM_W:0]     scale_sum;
  logic [32:0]        rem_sh;
  logic               rem_ge;
  logic [33:0]        res_sum;
  logic [33:0]        new_off_x;
  logic               accept;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.sample_value = out_val_r;
  assign out_ch.status = out_stat_r;
  assign out_ch.bar_total = out_total_r;

  // Bar RAM holds offset, height and area of each bar.
  assign {rd_off, rd_hgt, rd_area} = ram_rdata;
  assign new_area  = prod_r[63:FRAC_BITS];
  assign ram_wdata = {off_r, hgt_r, new_area};
  assign ram_we    = (state_r == ST_ADD_WR);

  hicdf_ram #(.WIDTH(RAM_W), .DEPTH(MAX_BARS)) u_bar_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (held_r[IDX_W-1:0]),
    .wdata (ram_wdata),
    .raddr (idx_nxt),
    .rdata (ram_rdata)
  );

  // Datapath terms used by the sequencer states.
  assign scale_sum = {1'b0, pick_r} + (u_r[0] ? {1'b0, sum_r} : '0);
  assign rem_sh    = {rem_r, dq_r[QW-1]};
  assign rem_ge    = rem_sh >= {1'b0, hgt_r};
  assign res_sum   = {{2{off_r[31]}}, off_r} + {2'b00, dq_r[31:0]};
  assign new_off_x = {{2{in_ch.bar_offset_in[31]}}, in_ch.bar_offset_in};

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    off_nxt       = off_r;
    wid_nxt       = wid_r;
    hgt_nxt       = hgt_r;
    u_nxt         = u_r;
    prod_nxt      = prod_r;
    held_nxt      = held_r;
    sum_nxt       = sum_r;
    prev_end_nxt  = prev_end_r;
    pick_nxt      = pick_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    val_nxt       = val_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_val_nxt   = out_val_r;
    out_stat_nxt  = out_stat_r;
    out_total_nxt = out_total_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt  = in_ch.cmd;
          off_nxt  = in_ch.bar_offset_in;
          wid_nxt  = in_ch.bar_width_in;
          hgt_nxt  = in_ch.bar_height_in;
          u_nxt    = in_ch.uniform_draw;
          val_nxt  = '0;
          stat_nxt = STAT_OK;
          state_nxt = ST_DONE;
          unique case (in_ch.cmd)
            CMD_CLEAR: begin
              held_nxt     = '0;
              sum_nxt      = '0;
              prev_end_nxt = '0;
            end
            CMD_ADD: begin
              if (held_r >= CNT_W'(MAX_BARS)) begin
                stat_nxt = STAT_FULL;
              end else if (held_r != '0 &&
                           $signed(new_off_x) < $signed(prev_end_r)) begin
                stat_nxt = STAT_OVERLAP;
              end else begin
                state_nxt = ST_ADD_MUL;
              end
            end
            CMD_SAMPLE: begin
              if (held_r == '0) begin
                stat_nxt = STAT_EMPTY;
              end else begin
                pick_nxt  = '0;
                cnt_nxt   = DCNT_W'(DATA_W);
                state_nxt = ST_SCALE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_ADD_MUL: begin
        prod_nxt  = 64'(wid_r) * 64'(hgt_r);
        state_nxt = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        held_nxt     = held_r + 1'b1;
        sum_nxt      = sum_r + SUM_W'(new_area);
        prev_end_nxt = {{2{off_r[31]}}, off_r} + {2'b00, wid_r};
        state_nxt    = ST_DONE;
      end
      ST_SCALE: begin
        // Shift-and-add product of total area and draw, keeping the top bits.
        pick_nxt = scale_sum[SUM_W:1];
        u_nxt    = {1'b0, u_r[31:1]};
        cnt_nxt  = cnt_r - 1'b1;
        idx_nxt  = '0;
        if (cnt_r == DCNT_W'(1)) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        // Skip bars whose area lies below the pick; stop at the last bar.
        if ((CNT_W'(idx_r) + 1'b1) < held_r && SUM_W'(rd_area) < pick_r) begin
          pick_nxt = pick_r - SUM_W'(rd_area);
          idx_nxt  = idx_r + 1'b1;
        end else begin
          off_nxt = rd_off;
          hgt_nxt = rd_hgt;
          if (rd_hgt == '0) begin
            val_nxt   = rd_off;
            state_nxt = ST_DONE;
          end else begin
            dq_nxt    = {pick_r, {FRAC_BITS{1'b0}}};
            rem_nxt   = '0;
            cnt_nxt   = DCNT_W'(QW);
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        // Restoring division, one quotient bit a cycle.
        rem_nxt = rem_ge ? 32'(rem_sh - {1'b0, hgt_r}) : rem_sh[31:0];
        dq_nxt  = {dq_r[QW-2:0], rem_ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // Offset plus quotient, saturated at the top of the signed range.
        if ((|dq_r[QW-1:32]) || (!res_sum[33] && (res_sum[32] || res_sum[31]))) begin
          val_nxt = 32'h7FFF_FFFF;
        end else begin
          val_nxt = res_sum[31:0];
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = val_r;
          out_stat_nxt  = stat_r;
          out_total_nxt = held_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_r      <= '0;
      sum_r       <= '0;
      prev_end_r  <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      sum_r       <= sum_nxt;
      prev_end_r  <= prev_end_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    off_r       <= off_nxt;
    wid_r       <= wid_nxt;
    hgt_r       <= hgt_nxt;
    u_r         <= u_nxt;
    prod_r      <= prod_nxt;
    pick_r      <= pick_nxt;
    dq_r        <= dq_nxt;
    rem_r       <= rem_nxt;
    val_r       <= val_nxt;
    stat_r      <= stat_nxt;
    out_val_r   <= out_val_nxt;
    out_stat_r  <= out_stat_nxt;
    out_total_r <= out_total_nxt;
  end

  // Checks on the sequencer and table bookkeeping.
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CNT_W'(MAX_BARS))
    else $error("bar count exceeds table depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ch.ready)
    else $error("ready stayed high after a transaction was accepted");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result issued outside the done state");

  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    held_r == '0 |-> sum_r == '0)
    else $error("total area nonzero with an empty table");

  a_cmd_add_path: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ADD_MUL |-> cmd_r == CMD_ADD)
    else $error("bar append entered without an add command");

endmodule
`default_nettype wire
